// ===== design/ae2f_pkg.sv =====
// ----------------------------------------------------------------------------
// ae2f_pkg: shared types and constants for the element-to-float32 unit
// Element kind codes, status codes, register indexes and stage structs.
// ----------------------------------------------------------------------------
`default_nettype none
package ae2f_pkg;

  localparam int RAW_W   = 64;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;

  // element kinds
  localparam logic [1:0] KIND_FLOAT = 2'd0;
  localparam logic [1:0] KIND_UINT  = 2'd1;
  localparam logic [1:0] KIND_SINT  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONFIN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // what the front stage hands to the normalizer
  // mode: pass = result fixed already, otherwise pack mag * 2^scale
  typedef struct packed {
    logic        pass;       // fixed_bits is final
    logic [31:0] fixed_bits; // final bits when pass
    logic        sign;
    logic [63:0] mag;
    logic signed [12:0] scale;
  } dec_t;

  // after leading-one search
  typedef struct packed {
    logic        pass;
    logic [31:0] fixed_bits;
    logic        sign;
    logic [63:0] mag;
    logic signed [12:0] scale;
    logic [5:0]  msb;
    logic        zero;
  } norm_t;

endpackage : ae2f_pkg
`default_nettype wire

// ===== design/array_element_to_float32_unit.sv =====
// ----------------------------------------------------------------------------
// array_element_to_float32_unit: array element to float32 converter
// Converts raw element bytes to float32 bits and a status code.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle unless the output stalls; four pipeline
// stages (decode, leading-one search, round, output) advance together under
// a global enable that holds every stage while the output is stalled.
// Reset (rst_n low, synchronous) empties the pipe and sets the registers
// to float kind, 4-byte width, little endian.
`default_nettype none
module array_element_to_float32_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] raw_bytes
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] value_bits, [33:32] status, zero fill
);
  import ae2f_pkg::*;

  logic [1:0] kind_r;
  logic [1:0] log2_r;
  logic       big_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_FLOAT;
      log2_r <= 2'd2;
      big_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND: kind_r <= cfg_data;
        REG_LOG2: log2_r <= cfg_data;
        REG_BIG:  big_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv;
  assign adv = !v4_r || out_tready;
  assign in_tready = adv;

  // stage 1: decode
  dec_t dec, s1_r;
  ae2f_decode u_dec (
    .raw_bytes(in_tdata), .kind(kind_r), .log2b(log2_r), .big(big_r), .dec(dec)
  );

  // stage 2: leading-one search
  norm_t nrm, s2_r;
  always_comb begin
    nrm.pass = s1_r.pass;
    nrm.fixed_bits = s1_r.fixed_bits;
    nrm.sign = s1_r.sign;
    nrm.mag = s1_r.mag;
    nrm.scale = s1_r.scale;
    nrm.zero = (s1_r.mag == 64'd0);
    nrm.msb = '0;
    for (int i = 0; i < 64; i++)
      if (s1_r.mag[i]) nrm.msb = 6'(i);
  end

  // stage 3: round
  logic [31:0] res;
  logic [31:0] s3_r;
  logic        inv_r;
  logic        inv2_r;
  ae2f_round u_rnd (.nrm(s2_r), .result(res));

  // stage 4: output register
  logic [31:0] val_r;
  logic [1:0]  st_r;
  logic [1:0]  st_nxt;
  always_comb begin
    if (inv2_r)                 st_nxt = ST_INVALID;
    else if (s3_r[30:23] == 8'hFF) st_nxt = ST_NONFIN;
    else                        st_nxt = ST_OK;
  end

  logic inv_in;
  assign inv_in = (kind_r == KIND_FLOAT) && (log2_r == 2'd0);
  logic inv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= dec;    inv1_r <= inv_in;
      s2_r   <= nrm;    inv_r  <= inv1_r;
      s3_r   <= res;    inv2_r <= inv_r;
      val_r  <= s3_r;   st_r   <= st_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {6'd0, st_r, val_r};

  // a stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  // invalid status only with zero value
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st_r == ST_INVALID |-> val_r == 32'd0)
    else $error("invalid status with nonzero value");
  // accepted item shows up after pipe depth with no stall
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready ##1 adv ##1 adv ##1 adv |=> out_tvalid)
    else $error("item lost in pipe");

endmodule : array_element_to_float32_unit
`default_nettype wire

// ===== design/ae2f_decode.sv =====
// ----------------------------------------------------------------------------
// ae2f_decode: byte reorder and field decode
// Puts the element bytes in value order and splits them into sign,
// magnitude and scale, or a final pattern for special encodings and 4-byte floats.
// ----------------------------------------------------------------------------
`default_nettype none
module ae2f_decode (
  input  wire logic [63:0]   raw_bytes,
  input  wire logic [1:0]    kind,
  input  wire logic [1:0]    log2b,
  input  wire logic          big,
  output ae2f_pkg::dec_t     dec
);
  import ae2f_pkg::*;

  logic [63:0] bits;
  logic [63:0] ext;
  logic        neg;
  logic [4:0]  he;
  logic [10:0] de;
  logic [51:0] df;

  // byte reorder: swap within the element width when big endian
  always_comb begin
    bits = '0;
    case (log2b)
      2'd0: bits = {56'd0, raw_bytes[7:0]};
      2'd1: bits = big ? {48'd0, raw_bytes[7:0], raw_bytes[15:8]}
                       : {48'd0, raw_bytes[15:0]};
      2'd2: bits = big ? {32'd0, raw_bytes[7:0], raw_bytes[15:8],
                          raw_bytes[23:16], raw_bytes[31:24]}
                       : {32'd0, raw_bytes[31:0]};
      default: bits = big ? {raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16],
                             raw_bytes[31:24], raw_bytes[39:32], raw_bytes[47:40],
                             raw_bytes[55:48], raw_bytes[63:56]}
                          : raw_bytes;
    endcase
  end

  assign he = bits[14:10];
  assign de = bits[62:52];
  assign df = bits[51:0];

  // sign extension for signed kinds
  always_comb begin
    neg = 1'b0;
    ext = bits;
    case (log2b)
      2'd0: begin neg = bits[7];  ext = {{56{bits[7]}}, bits[7:0]}; end
      2'd1: begin neg = bits[15]; ext = {{48{bits[15]}}, bits[15:0]}; end
      2'd2: begin neg = bits[31]; ext = {{32{bits[31]}}, bits[31:0]}; end
      default: begin neg = bits[63]; ext = bits; end
    endcase
  end

  always_comb begin
    dec = '0;
    if (kind == KIND_FLOAT) begin
      case (log2b)
        2'd0: dec.pass = 1'b1; // invalid, bits zero
        2'd1: begin
          dec.sign = bits[15];
          if (he == 5'd31) begin
            dec.pass = 1'b1;
            dec.fixed_bits = {bits[15], 8'hFF, 23'd0};
          end else if (he == 5'd0) begin
            dec.mag = {54'd0, bits[9:0]};
            dec.scale = -13'sd24;
          end else begin
            dec.mag = {53'd0, 1'b1, bits[9:0]};
            dec.scale = $signed({8'd0, he}) - 13'sd25;
          end
        end
        2'd2: begin
          dec.pass = 1'b1;
          dec.fixed_bits = bits[31:0];
        end
        default: begin
          dec.sign = bits[63];
          if (de == 11'h7FF) begin
            dec.pass = 1'b1;
            dec.fixed_bits = (df == 52'd0) ? {bits[63], 8'hFF, 23'd0}
                           : {bits[63], 9'h1FF, df[50:29]};
          end else if (de == 11'd0) begin
            dec.mag = {12'd0, df};
            dec.scale = -13'sd1074;
          end else begin
            dec.mag = {11'd0, 1'b1, df};
            dec.scale = $signed({2'd0, de}) - 13'sd1075;
          end
        end
      endcase
    end else if (kind == KIND_UINT) begin
      dec.mag = bits;
    end else begin
      dec.sign = neg;
      dec.mag = neg ? (64'd0 - ext) : bits;
    end
  end

endmodule : ae2f_decode
`default_nettype wire

// ===== design/ae2f_round.sv =====
// ----------------------------------------------------------------------------
// ae2f_round: exponent, alignment shift and round to nearest even
// Takes a normalized magnitude and produces the float32 pattern.
// ----------------------------------------------------------------------------
`default_nettype none
module ae2f_round (
  input  wire ae2f_pkg::norm_t nrm,
  output logic [31:0]          result
);
  import ae2f_pkg::*;

  logic signed [13:0] x;
  logic signed [13:0] shift;
  logic               sub;
  logic [63:0]        q;
  logic [63:0]        rem;
  logic [63:0]        half;
  logic [63:0]        mask;
  logic [5:0]         sh;
  logic [31:0]        sgn;

  always_comb begin
    sgn   = {nrm.sign, 31'd0};
    x     = $signed({8'd0, nrm.msb}) + $signed({nrm.scale[12], nrm.scale});
    sub   = x < -14'sd126;
    shift = sub ? (-14'sd149 - $signed({nrm.scale[12], nrm.scale}))
                : ($signed({8'd0, nrm.msb}) - 14'sd23);
    sh    = shift[5:0];
    q     = '0;
    mask  = '0;
    rem   = '0;
    half  = '0;
    if (shift <= 14'sd0) begin
      q = nrm.mag << (6'(-shift));
    end else if (shift > 14'sd62) begin
      q = '0;
    end else begin
      mask = (64'd1 << sh) - 64'd1;
      rem  = nrm.mag & mask;
      half = 64'd1 << (sh - 6'd1);
      q    = nrm.mag >> sh;
      if (rem > half || (rem == half && q[0]))
        q = q + 64'd1;
    end
    if (nrm.pass)
      result = nrm.fixed_bits;
    else if (nrm.zero)
      result = sgn;
    else if (x > 14'sd127)
      result = sgn | 32'h7F800000;
    else if (sub)
      result = sgn | q[31:0];
    else
      result = sgn | (({18'd0, 14'(x + 14'sd126)} << 23) + q[31:0]);
  end

endmodule : ae2f_round
`default_nettype wire

// ===== bench/array_element_to_float32_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_element_to_float32_unit_test: self-checking bench for the converter
// Drives raw element bytes under every kind, width and byte order, predicts
// the float32 bits and status of each transfer, and compares in order.
// ----------------------------------------------------------------------------
module array_element_to_float32_unit_test;
  import ae2f_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [1:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  array_element_to_float32_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] bits;
  } conv_t;

  // predictor copy of the registers
  logic [1:0] kind_q = KIND_FLOAT;
  logic [1:0] log2_q = 2'd2;
  logic       big_q  = 1'b0;

  conv_t  pending[$];
  int     errors = 0;
  int     send_idle = 0;
  int     recv_stall = 0;

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // round mag * 2^scale to float32, nearest even
  function automatic logic [31:0] round_to_single(input logic sign,
                                                  input logic [63:0] mag,
                                                  input int scale);
    int p, x, sh;
    logic [63:0] q, rem, half;
    logic sub;
    if (mag == 0) return {sign, 31'd0};
    p = 63;
    while (p > 0 && !mag[p]) p--;
    x = p + scale;
    if (x > 127) return {sign, 8'hFF, 23'd0};
    sub = x < -126;
    sh = sub ? (-149 - scale) : (p - 23);
    if (sh <= 0) q = mag << (-sh);
    else if (sh > 62) q = 0;
    else begin
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      q = mag >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (sub) return {sign, 31'd0} | q[31:0];
    return {sign, 31'd0} | ((32'(x + 126) << 23) + q[31:0]);
  endfunction

  function automatic conv_t convert_element(input logic [63:0] raw);
    int nb, top;
    logic [63:0] v, ext;
    logic [31:0] r;
    logic s;
    int e;
    conv_t c;
    nb = 1 << log2_q;
    v = 0;
    for (int i = 0; i < nb; i++)
      v[8*(big_q ? nb-1-i : i) +: 8] = raw[8*i +: 8];
    if (kind_q == KIND_FLOAT) begin
      if (nb == 1) return '{ST_INVALID, 32'd0};
      if (nb == 2) begin
        s = v[15]; e = int'(v[14:10]);
        if (e == 0) r = round_to_single(s, {54'd0, v[9:0]}, -24);
        else if (e == 31) r = {s, 8'hFF, 23'd0};
        else r = round_to_single(s, {53'd0, 1'b1, v[9:0]}, e - 25);
      end else if (nb == 4) r = v[31:0];
      else begin
        s = v[63]; e = int'(v[62:52]);
        if (e == 2047) r = (v[51:0] == 0) ? {s, 8'hFF, 23'd0}
                                          : {s, 8'hFF, v[51:29]} | 32'h0040_0000;
        else if (e == 0) r = round_to_single(s, {12'd0, v[51:0]}, -1074);
        else r = round_to_single(s, {11'd0, 1'b1, v[51:0]}, e - 1075);
      end
    end else if (kind_q == KIND_UINT) r = round_to_single(1'b0, v, 0);
    else begin
      // signed, also for the unused kind code
      top = 8*nb - 1;
      if (v[top]) begin
        ext = v;
        if (nb < 8) ext |= ~((64'd1 << (8*nb)) - 1);
        r = round_to_single(1'b1, -ext, 0);
      end else r = round_to_single(1'b0, v, 0);
    end
    c.bits = r;
    c.status = (r[30:23] == 8'hFF) ? ST_NONFIN : ST_OK;
    return c;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KIND) kind_q = val;
    else if (idx == REG_LOG2) log2_q = val;
    else if (idx == REG_BIG) big_q = val[0];
  endtask

  task automatic set_format(input logic [1:0] k, input logic [1:0] l,
                            input logic b);
    write_reg(REG_KIND, k);
    write_reg(REG_LOG2, l);
    write_reg(REG_BIG, {1'b0, b});
  endtask

  // one transfer on the input; the predictor queues its result
  task automatic send_element(input logic [63:0] raw);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending.insert(pending.size(), convert_element(raw));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // receiver with random stalls
  always @(negedge clk)
    out_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

  always @(posedge clk) begin
    conv_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0)
        report_mismatch("unexpected result", out_tdata, 40'd0);
      else begin
        want = pending.pop_front();
        if (out_tdata[31:0] !== want.bits)
          report_mismatch("value_bits", out_tdata, {6'd0, want});
        if (out_tdata[33:32] !== want.status)
          report_mismatch("status", out_tdata, {6'd0, want});
      end
    end
  end

  // directed rows: format, raw bytes, result typed in where obvious
  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  lg;
    logic        big;
    logic [63:0] raw;
    logic        known;
    conv_t       want;
  } row_t;

  row_t rows[] = '{
    '{KIND_FLOAT, 2'd2, 1'b0, 64'h0000_0000_3F80_0000, 1'b1, '{ST_OK, 32'h3F80_0000}},
    '{KIND_FLOAT, 2'd2, 1'b0, 64'hFFFF_FFFF_7F80_0000, 1'b1, '{ST_NONFIN, 32'h7F80_0000}},
    '{KIND_FLOAT, 2'd2, 1'b1, 64'h0000_0000_0000_80FF, 1'b1, '{ST_NONFIN, 32'hFF80_0000}},
    '{KIND_FLOAT, 2'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_INVALID, 32'd0}},
    '{KIND_FLOAT, 2'd1, 1'b0, 64'h0000_0000_0000_7C00, 1'b1, '{ST_NONFIN, 32'h7F80_0000}},
    '{KIND_FLOAT, 2'd1, 1'b0, 64'h0000_0000_0000_FE01, 1'b1, '{ST_NONFIN, 32'hFF80_0000}},
    '{KIND_FLOAT, 2'd1, 1'b0, 64'h0000_0000_0000_8000, 1'b1, '{ST_OK, 32'h8000_0000}},
    '{KIND_FLOAT, 2'd1, 1'b0, 64'h0000_0000_0000_0001, 1'b0, '{ST_OK, 32'd0}},
    '{KIND_FLOAT, 2'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FF7B, 1'b0, '{ST_OK, 32'd0}},
    '{KIND_FLOAT, 2'd3, 1'b0, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1, '{ST_NONFIN, 32'h7F80_0000}},
    '{KIND_FLOAT, 2'd3, 1'b0, 64'hFFF8_0000_2000_0000, 1'b1, '{ST_NONFIN, 32'hFFC0_0001}},
    '{KIND_FLOAT, 2'd3, 1'b0, 64'h7FF0_0000_0000_0001, 1'b1, '{ST_NONFIN, 32'h7FC0_0000}},
    '{KIND_FLOAT, 2'd3, 1'b1, 64'h0000_0000_0000_0080, 1'b1, '{ST_OK, 32'h8000_0000}},
    '{KIND_FLOAT, 2'd3, 1'b0, 64'h0000_0000_0000_0001, 1'b1, '{ST_OK, 32'h0000_0000}},
    '{KIND_FLOAT, 2'd3, 1'b0, 64'h3FF0_0000_1000_0000, 1'b0, '{ST_OK, 32'd0}},
    '{KIND_UINT,  2'd3, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_OK, 32'h5F80_0000}},
    '{KIND_UINT,  2'd0, 1'b0, 64'h0000_0000_0000_00FF, 1'b1, '{ST_OK, 32'h437F_0000}},
    '{KIND_UINT,  2'd2, 1'b1, 64'h0000_0000_0100_0001, 1'b0, '{ST_OK, 32'd0}},
    '{KIND_SINT,  2'd0, 1'b0, 64'h0000_0000_0000_0080, 1'b1, '{ST_OK, 32'hC300_0000}},
    '{KIND_SINT,  2'd1, 1'b1, 64'h0000_0000_0000_FFFF, 1'b1, '{ST_OK, 32'hBF80_0000}},
    '{KIND_SINT,  2'd3, 1'b0, 64'h8000_0000_0000_0000, 1'b1, '{ST_OK, 32'hDF00_0000}},
    '{KIND_SINT,  2'd2, 1'b0, 64'h0000_0000_7FFF_FFFF, 1'b1, '{ST_OK, 32'h4F00_0000}},
    '{2'd3,       2'd1, 1'b0, 64'h0000_0000_0000_8000, 1'b1, '{ST_OK, 32'hC700_0000}},
    '{KIND_UINT,  2'd1, 1'b0, 64'h0000_0000_0000_0000, 1'b1, '{ST_OK, 32'h0000_0000}}
  };

  // bytes shaped toward interesting values for the current format
  function automatic logic [63:0] random_raw;
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: r = 64'd0;
      1: r = '1;
      2: r = r & 64'h0000_0000_0000_0FFF;
      3: r = r | 64'h7FF0_0000_0000_0000;
      4: r = r & 64'h800F_FFFF_FFFF_FFFF;
      5: r = {r[63:16], 16'h7C00 | (r[15:0] & 16'h83FF)};
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < rows.size(); i++) begin
      if (rows[i].kind != kind_q || rows[i].lg != log2_q || rows[i].big != big_q) begin
        drain();
        set_format(rows[i].kind, rows[i].lg, rows[i].big);
      end
      send_element(rows[i].raw);
      if (rows[i].known && pending[$] !== rows[i].want)
        report_mismatch("table row", {6'd0, pending[$]}, {6'd0, rows[i].want});
    end

    // random phases over every idling mode and many formats
    for (int ph = 0; ph < 40; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      set_format(2'($urandom_range(3)), 2'($urandom_range(3)),
                 1'($urandom_range(1)));
      repeat (30) send_element(random_raw());
    end
    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
